[rtl/assert_macros.svh]
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define RLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rlp assertion failed");

// Clocked check that also runs during reset.
`define RLP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("rlp assertion failed during or after reset");

`endif

[rtl/rlp_pkg.sv]
// Types and constants of the rate-limited positioner.
package rlp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_COMPLETED = 2'd2,
    ST_ERROR     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_SPEED = 2'd1
  } cfg_idx_e;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPEED_W = 31;

  localparam logic [32:0] NEAR_MOVE   = 33'd30;
  localparam logic [30:0] NEAR_MOVE_S = 31'd30;
  localparam logic [32:0] NEAR_TGT    = 33'd10;
  localparam logic [3:0]  SETTLE_NEED = 4'd5;
  localparam logic [3:0]  SETTLE_SAT  = 4'd10;
  localparam logic [7:0]  TMO_LIMIT   = 8'd200;
  localparam logic [7:0]  TMO_SAT     = 8'd255;
  localparam logic [2:0]  RETRY_MAX   = 3'd4;
  localparam logic [2:0]  RETRY_SAT   = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       settle;
    logic [7:0]       tmo;
    logic [2:0]       retry;
    status_e          status;
  } state_t;

  typedef struct packed {
    logic notify;
    logic issued;
  } flags_t;

endpackage

[rtl/rlp_tick.sv]
// One control tick: position step, settle detector, timeout watchdog, ack and start.
module rlp_tick import rlp_pkg::*; (
  input  state_t             state_i,
  input  logic               mode_i,
  input  logic [SPEED_W-1:0] speed_i,
  input  logic [POS_W-1:0]   target_i,
  input  logic               start_i,
  input  logic               ack_i,
  output state_t             state_o,
  output flags_t             flags_o
);

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [32:0]        speed_x;
  logic               over;
  logic [POS_W-1:0]   step;
  logic [POS_W-1:0]   pos_new;
  logic               settled;
  logic [3:0]         settle_inc;
  logic               settle_done;
  status_e            status_a;
  status_e            status_c;
  status_e            status_d;
  logic               run_a;
  logic [7:0]         tmo_inc;
  logic               timeout_hit;
  logic [2:0]         retry_inc;
  logic               retry_err;
  logic               ack_go;
  logic               start_go;

  assign diff    = $signed({target_i[POS_W-1], target_i})
                 - $signed({state_i.pos[POS_W-1], state_i.pos});
  assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
  assign speed_x = {2'b00, speed_i};
  assign over    = mag > speed_x;

  // clamp the step to the profile speed; it never overshoots the target
  assign step    = over ? (diff[32] ? 32'(-speed_x) : speed_x[31:0]) : diff[31:0];
  assign pos_new = state_i.pos + step;

  // position_before always equals the old position, so the move is |step|
  // and the residual error is |diff| less the step
  assign settled = (state_i.status == ST_RUNNING)
                 && ((mag < NEAR_MOVE) || (speed_i < NEAR_MOVE_S))
                 && (mag < (speed_x + NEAR_TGT));

  assign settle_inc  = settled ? state_i.settle + 4'd1 : state_i.settle;
  assign settle_done = settle_inc > SETTLE_NEED;
  assign status_a    = settle_done ? ST_COMPLETED : state_i.status;
  assign run_a       = status_a == ST_RUNNING;

  assign tmo_inc     = (state_i.tmo != TMO_SAT) ? state_i.tmo + 8'd1 : state_i.tmo;
  assign timeout_hit = run_a && (tmo_inc > TMO_LIMIT);
  assign retry_inc   = (state_i.retry != RETRY_SAT) ? state_i.retry + 3'd1
                                                     : state_i.retry;
  assign retry_err   = timeout_hit && (retry_inc > RETRY_MAX);

  assign status_c = retry_err ? ST_ERROR : status_a;
  assign ack_go   = ack_i && ((status_c == ST_COMPLETED) || (status_c == ST_ERROR));
  assign status_d = ack_go ? ST_IDLE : status_c;
  assign start_go = start_i && (status_d == ST_IDLE);

  // next state
  always_comb begin
    state_o = state_i;
    if (mode_i) begin
      state_o.pos    = pos_new;
      state_o.settle = settle_done ? SETTLE_SAT : settle_inc;
      state_o.status = status_d;
      if (run_a) begin
        state_o.tmo = tmo_inc;
        if (timeout_hit) begin
          state_o.settle = 4'd0;
          state_o.tmo    = 8'd0;
          state_o.retry  = retry_inc;
        end
      end
      if (ack_go) begin
        state_o.settle = 4'd0;
      end
      if (start_go) begin
        state_o.status = ST_RUNNING;
        state_o.settle = 4'd0;
        state_o.tmo    = 8'd0;
        state_o.retry  = 3'd0;
      end
    end
  end

  // per-tick flags
  always_comb begin
    flags_o.notify = mode_i
                   && ((settle_done && (state_i.status != ST_COMPLETED)) || retry_err);
    flags_o.issued = mode_i && (timeout_hit || start_go);
  end

endmodule

[rtl/rate_limited_positioner_with_watchdog_top.sv]
// Top level of the rate-limited positioner with settle detector and timeout watchdog.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | in
//  tick in | in_valid_i/in_ready_o, target, start, acknowledge | in
//  result  | out_valid_o/out_ready_i, position, status, flags | out
//
// One tick a cycle sustained while the result is not stalled; a tick leaves
// the input register and lands in the result register, where it is offered at once.
// The state registers update as the tick moves on, feeding the next tick.
// A stalled result holds the input register; cfg_ready_o is always high.
// Reset puts the block idle at position zero with mode disabled, speed zero.
module rate_limited_positioner_with_watchdog_top import rlp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [POS_W-1:0]   target_position_i,
  input  logic               start_request_i,
  input  logic               acknowledge_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [POS_W-1:0]   actual_position_o,
  output logic [1:0]         move_status_o,
  output logic               notify_o,
  output logic               command_issued_o,
  output logic [2:0]         retries_used_o
);

  `include "assert_macros.svh"

  logic               mode_q;
  logic [SPEED_W-1:0] speed_q;
  state_t             state_q, state_d;
  flags_t             flags;

  logic               in_vld_q;
  logic [POS_W-1:0]   target_q;
  logic               start_q;
  logic               ack_q;
  logic               fire;

  logic               out_vld_q;
  logic [POS_W-1:0]   pos_out_q;
  status_e            status_out_q;
  flags_t             flags_out_q;
  logic [2:0]         retry_out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      speed_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_SPEED: speed_q <= cfg_data_i[SPEED_W-1:0];
        default:   ;
      endcase
    end
  end

  // advance the tick when the result register is free or being drained
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      target_q <= target_position_i;
      start_q  <= start_request_i;
      ack_q    <= acknowledge_i;
    end
  end

  rlp_tick u_tick (
    .state_i  (state_q),
    .mode_i   (mode_q),
    .speed_i  (speed_q),
    .target_i (target_q),
    .start_i  (start_q),
    .ack_i    (ack_q),
    .state_o  (state_d),
    .flags_o  (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pos: '0, settle: '0, tmo: '0, retry: '0, status: ST_IDLE};
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pos_out_q    <= state_d.pos;
      status_out_q <= state_d.status;
      flags_out_q  <= flags;
      retry_out_q  <= state_d.retry;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign actual_position_o = pos_out_q;
  assign move_status_o     = status_out_q;
  assign notify_o          = flags_out_q.notify;
  assign command_issued_o  = flags_out_q.issued;
  assign retries_used_o    = retry_out_q;

  `RLP_ASSERT(a_fire_gives_result, fire |=> out_valid_o)
  `RLP_ASSERT(a_disabled_holds_state, (fire && !mode_q) |-> (state_d == state_q))
  `RLP_ASSERT_ALWAYS(a_counters_bounded, !rst_ni || ((state_q.tmo <= TMO_LIMIT) && (state_q.retry <= RETRY_MAX + 3'd1)))
  `RLP_ASSERT_ALWAYS(a_settle_codes, !rst_ni || (state_q.settle <= SETTLE_NEED) || (state_q.settle == SETTLE_SAT))

endmodule
